>>> rtl/potq_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// potq_pkg: priority ordered task table shared definitions
// Field widths, operation and status codes, and the structs that travel
// between the control logic and the row of table cells.
// ----------------------------------------------------------------------------
package potq_pkg;

  localparam int OP_W     = 2;
  localparam int KEY_W    = 16;
  localparam int RANK_W   = 8;
  localparam int HANDLE_W = 16;
  localparam int STAT_W   = 2;
  localparam int OCC_W    = 5;

  localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
  localparam logic [OP_W-1:0] OP_REMOVE = 2'd1;
  localparam logic [OP_W-1:0] OP_FIND   = 2'd2;

  localparam logic [STAT_W-1:0] STAT_OK   = 2'd0;
  localparam logic [STAT_W-1:0] STAT_FULL = 2'd1;
  localparam logic [STAT_W-1:0] STAT_MISS = 2'd2;

  typedef struct packed {
    logic [KEY_W-1:0]    key;
    logic [RANK_W-1:0]   rank;
    logic [HANDLE_W-1:0] handle;
  } entry_t;

  typedef struct packed {
    logic                hit;
    logic [RANK_W-1:0]   rank;
    logic [HANDLE_W-1:0] handle;
  } carry_t;

  typedef struct packed {
    logic                insert;
    logic                remove;
    logic                scan;
    logic                clear;
    logic [KEY_W-1:0]    key;
    logic [RANK_W-1:0]   rank;
    logic [HANDLE_W-1:0] handle;
  } cell_cmd_t;

endpackage
`default_nettype wire

>>> rtl/potq_cell.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// potq_cell: one slot of the sorted task table
// Holds one entry, shifts toward or away from its neighbors on insert and
// remove, and passes the first-match search result to the next cell.
// ----------------------------------------------------------------------------
module potq_cell #(
  parameter int IDX   = 0,
  parameter int CNT_W = 5
) (
  input  wire                      clk,
  input  wire                      rst,
  input  potq_pkg::cell_cmd_t      cmd,
  input  wire [CNT_W-1:0]          count,
  input  potq_pkg::entry_t         left,
  input  wire                      left_gt,
  input  potq_pkg::entry_t         right,
  input  potq_pkg::carry_t         carry_in,
  output potq_pkg::entry_t         ent,
  output logic                     gt,
  output potq_pkg::carry_t         carry_out
);

  logic live;
  logic match;

  assign live  = CNT_W'(IDX) < count;
  assign gt    = live && (ent.rank > cmd.rank);
  assign match = live && (ent.key == cmd.key);

  always_ff @(posedge clk) begin
    if (cmd.insert) begin
      if (!left_gt) begin
        ent <= left;
      end else if (!gt) begin
        ent <= '{key: cmd.key, rank: cmd.rank, handle: cmd.handle};
      end
    end else if (cmd.remove && (carry_in.hit || match)) begin
      ent <= right;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.clear) begin
      carry_out.hit <= 1'b0;
    end else if (cmd.scan) begin
      if (carry_in.hit) begin
        carry_out <= carry_in;
      end else begin
        carry_out <= '{hit: match, rank: ent.rank, handle: ent.handle};
      end
    end
  end

endmodule
`default_nettype wire

>>> rtl/priority_ordered_task_table_top.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// priority_ordered_task_table_top: sorted priority task table
// Up to DEPTH entries kept in descending rank order in a row of cells;
// insert, remove by id and find by id, one result per operation.
// ----------------------------------------------------------------------------
//  channel | handshake          | fields
//  in      | in_valid/in_stall  | operation, entry_key, rank, handle
//  out     | out_valid/out_stall| status, found_rank, found_handle, occupancy
//
//  An insert is latched, then every cell compares and shifts in parallel; the
//  unused code and an insert into a full table are latched and answered with no shift.
//  Remove and find are latched, then the first-match result ripples one cell
//  per cycle down the row, then a remove closes the gap in all cells in parallel.
//  Reset empties the table at once; no clearing pass.
//  A result waiting on out_stall holds, and the next item is still taken.
// ----------------------------------------------------------------------------
module priority_ordered_task_table_top #(
  parameter int DEPTH = 16
) (
  input  wire                              clk,
  input  wire                              rst,
  input  wire                              in_valid,
  output logic                             in_stall,
  input  wire [potq_pkg::OP_W-1:0]         operation,
  input  wire [potq_pkg::KEY_W-1:0]        entry_key,
  input  wire [potq_pkg::RANK_W-1:0]       rank,
  input  wire [potq_pkg::HANDLE_W-1:0]     handle,
  output logic                             out_valid,
  input  wire                              out_stall,
  output logic [potq_pkg::STAT_W-1:0]      status,
  output logic [potq_pkg::RANK_W-1:0]      found_rank,
  output logic [potq_pkg::HANDLE_W-1:0]    found_handle,
  output logic [potq_pkg::OCC_W-1:0]       occupancy
);

  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int SCAN_W = $clog2(DEPTH);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_EXEC  = 2'd1;
  localparam logic [1:0] ST_SCAN  = 2'd2;
  localparam logic [1:0] ST_APPLY = 2'd3;

  logic [1:0]                      state, state_next;
  logic [SCAN_W-1:0]               scan_cnt, scan_cnt_next;
  logic [CNT_W-1:0]                count, count_next;
  logic [potq_pkg::OP_W-1:0]       op_q;
  logic [potq_pkg::KEY_W-1:0]      key_q;
  logic [potq_pkg::RANK_W-1:0]     rank_q;
  logic [potq_pkg::HANDLE_W-1:0]   handle_q;

  logic                            load;
  logic [potq_pkg::STAT_W-1:0]     status_next;
  logic [potq_pkg::RANK_W-1:0]     found_rank_next;
  logic [potq_pkg::HANDLE_W-1:0]   found_handle_next;
  logic                            out_free;

  potq_pkg::cell_cmd_t             cmd;
  potq_pkg::entry_t                ent_s   [DEPTH];
  logic                            gt_s    [DEPTH];
  potq_pkg::carry_t                carry_s [DEPTH];
  potq_pkg::carry_t                res;

  assign in_stall = (state != ST_IDLE);
  assign out_free = !out_valid || !out_stall;
  assign res      = carry_s[DEPTH-1];

  always_comb begin
    state_next        = state;
    scan_cnt_next     = scan_cnt;
    count_next        = count;
    load              = 1'b0;
    status_next       = potq_pkg::STAT_OK;
    found_rank_next   = '0;
    found_handle_next = '0;
    cmd               = '0;
    cmd.key           = key_q;
    cmd.rank          = rank_q;
    cmd.handle        = handle_q;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          state_next = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (op_q == potq_pkg::OP_REMOVE || op_q == potq_pkg::OP_FIND) begin
          cmd.clear     = 1'b1;
          scan_cnt_next = '0;
          state_next    = ST_SCAN;
        end else if (out_free) begin
          load       = 1'b1;
          state_next = ST_IDLE;
          if (op_q == potq_pkg::OP_INSERT) begin
            if (count == CNT_W'(DEPTH)) begin
              status_next = potq_pkg::STAT_FULL;
            end else begin
              cmd.insert = 1'b1;
              count_next = count + CNT_W'(1);
            end
          end
        end
      end
      ST_SCAN: begin
        cmd.scan = 1'b1;
        if (scan_cnt == SCAN_W'(DEPTH - 1)) begin
          state_next = ST_APPLY;
        end else begin
          scan_cnt_next = scan_cnt + SCAN_W'(1);
        end
      end
      ST_APPLY: begin
        if (out_free) begin
          load       = 1'b1;
          state_next = ST_IDLE;
          if (res.hit) begin
            found_rank_next   = res.rank;
            found_handle_next = res.handle;
            if (op_q == potq_pkg::OP_REMOVE) begin
              cmd.remove = 1'b1;
              count_next = count - CNT_W'(1);
            end
          end else begin
            status_next = potq_pkg::STAT_MISS;
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      scan_cnt  <= '0;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      state    <= state_next;
      scan_cnt <= scan_cnt_next;
      count    <= count_next;
      if (load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      op_q     <= operation;
      key_q    <= entry_key;
      rank_q   <= rank;
      handle_q <= handle;
    end
    if (load) begin
      status       <= status_next;
      found_rank   <= found_rank_next;
      found_handle <= found_handle_next;
      occupancy    <= potq_pkg::OCC_W'(count_next);
    end
  end

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    potq_pkg::entry_t left_ent;
    potq_pkg::entry_t right_ent;
    potq_pkg::carry_t cin;
    logic             lgt;

    if (i == 0) begin : g_head
      assign left_ent = '0;
      assign lgt      = 1'b1;
      assign cin      = '0;
    end else begin : g_body
      assign left_ent = ent_s[i-1];
      assign lgt      = gt_s[i-1];
      assign cin      = carry_s[i-1];
    end

    if (i == DEPTH - 1) begin : g_tail
      assign right_ent = '0;
    end else begin : g_mid
      assign right_ent = ent_s[i+1];
    end

    potq_cell #(
      .IDX   (i),
      .CNT_W (CNT_W)
    ) u_cell (
      .clk       (clk),
      .rst       (rst),
      .cmd       (cmd),
      .count     (count),
      .left      (left_ent),
      .left_gt   (lgt),
      .right     (right_ent),
      .carry_in  (cin),
      .ent       (ent_s[i]),
      .gt        (gt_s[i]),
      .carry_out (carry_s[i])
    );
  end

endmodule
`default_nettype wire

>>> sim/potq_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// potq_checker: result checker for the priority ordered task table
// Watches both channels. Each input transfer is applied to a private sorted
// table, which yields the status, found fields and occupancy that the block
// must return. Output transfers are compared in order, field by field.
// ----------------------------------------------------------------------------
module potq_checker
  import potq_pkg::*;
#(
  parameter int DEPTH = 16
) (
  input  wire                clk,
  input  wire                rst,
  input  wire                in_valid,
  input  wire                in_stall,
  input  wire [OP_W-1:0]     operation,
  input  wire [KEY_W-1:0]    entry_key,
  input  wire [RANK_W-1:0]   rank,
  input  wire [HANDLE_W-1:0] handle,
  input  wire                out_valid,
  input  wire                out_stall,
  input  wire [STAT_W-1:0]   status,
  input  wire [RANK_W-1:0]   found_rank,
  input  wire [HANDLE_W-1:0] found_handle,
  input  wire [OCC_W-1:0]    occupancy,
  output int                 errors,
  output int                 pending
);

  typedef struct packed {
    logic [STAT_W-1:0]   status;
    logic [RANK_W-1:0]   found_rank;
    logic [HANDLE_W-1:0] found_handle;
    logic [OCC_W-1:0]    occupancy;
  } outcome_t;

  logic [KEY_W-1:0]    tbl_key    [DEPTH];
  logic [RANK_W-1:0]   tbl_rank   [DEPTH];
  logic [HANDLE_W-1:0] tbl_handle [DEPTH];
  int                  tbl_count;
  outcome_t            outcome_q [$];

  function automatic outcome_t apply_table_op(input logic [OP_W-1:0] op,
                                              input logic [KEY_W-1:0] key,
                                              input logic [RANK_W-1:0] rnk,
                                              input logic [HANDLE_W-1:0] hnd);
    outcome_t res;
    int       pos;
    int       i;
    res = '0;
    if (op == OP_INSERT) begin
      if (tbl_count >= DEPTH) begin
        res.status = STAT_FULL;
      end else begin
        pos = 0;
        while (pos < tbl_count && tbl_rank[pos] > rnk) pos++;
        for (i = tbl_count; i > pos; i--) begin
          tbl_key[i]    = tbl_key[i-1];
          tbl_rank[i]   = tbl_rank[i-1];
          tbl_handle[i] = tbl_handle[i-1];
        end
        tbl_key[pos]    = key;
        tbl_rank[pos]   = rnk;
        tbl_handle[pos] = hnd;
        tbl_count++;
      end
    end else if (op == OP_REMOVE || op == OP_FIND) begin
      pos = 0;
      while (pos < tbl_count && tbl_key[pos] != key) pos++;
      if (pos >= tbl_count) begin
        res.status = STAT_MISS;
      end else begin
        res.found_rank   = tbl_rank[pos];
        res.found_handle = tbl_handle[pos];
        if (op == OP_REMOVE) begin
          for (i = pos; i + 1 < tbl_count; i++) begin
            tbl_key[i]    = tbl_key[i+1];
            tbl_rank[i]   = tbl_rank[i+1];
            tbl_handle[i] = tbl_handle[i+1];
          end
          tbl_count--;
        end
      end
    end
    res.occupancy = OCC_W'(tbl_count);
    return res;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    if (errors < 40) begin
      $display("%0t ns: %s got %0h, expected %0h", $time, what, got, want);
    end
    errors++;
  endtask

  always @(posedge clk) begin
    outcome_t want;
    if (rst) begin
      tbl_count = 0;
      errors    = 0;
      outcome_q.delete();
      pending <= 0;
    end else begin
      if (in_valid && !in_stall) begin
        outcome_q.push_back(apply_table_op(operation, entry_key, rank, handle));
      end
      if (out_valid && !out_stall) begin
        if (outcome_q.size() == 0) begin
          report_mismatch("result with nothing outstanding, status", int'(status), 0);
        end else begin
          want = outcome_q.pop_front();
          if (status !== want.status)
            report_mismatch("status", int'(status), int'(want.status));
          if (found_rank !== want.found_rank)
            report_mismatch("found_rank", int'(found_rank), int'(want.found_rank));
          if (found_handle !== want.found_handle)
            report_mismatch("found_handle", int'(found_handle),
                            int'(want.found_handle));
          if (occupancy !== want.occupancy)
            report_mismatch("occupancy", int'(occupancy), int'(want.occupancy));
        end
      end
      pending <= outcome_q.size();
    end
  end

endmodule

>>> sim/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: testbench for the priority ordered task table
// Runs a directed pass over empty, full, duplicate and equal-rank cases,
// then blocks of random operations that swing the table between empty and
// full, with random input gaps and output stalls. The checker predicts
// every result; this module drives stimulus and reports the verdict.
// ----------------------------------------------------------------------------
module tb_top;
  import potq_pkg::*;

  localparam int DEPTH = 16;
  localparam logic [OP_W-1:0] OP_NONE = 2'd3;
  localparam int LIMIT       = 800000;
  localparam int BLOCKS      = 14;
  localparam int BLOCK_ITEMS = 100;

  logic                clk;
  logic                rst;
  logic                in_valid;
  logic                in_stall;
  logic [OP_W-1:0]     operation;
  logic [KEY_W-1:0]    entry_key;
  logic [RANK_W-1:0]   rank;
  logic [HANDLE_W-1:0] handle;
  logic                out_valid;
  logic                out_stall;
  logic [STAT_W-1:0]   status;
  logic [RANK_W-1:0]   found_rank;
  logic [HANDLE_W-1:0] found_handle;
  logic [OCC_W-1:0]    occupancy;
  int                  errors;
  int                  pending;
  int                  sent = 0;
  int                  cycles = 0;

  priority_ordered_task_table_top #(.DEPTH(DEPTH)) uut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .operation(operation), .entry_key(entry_key), .rank(rank), .handle(handle),
    .out_valid(out_valid), .out_stall(out_stall),
    .status(status), .found_rank(found_rank), .found_handle(found_handle),
    .occupancy(occupancy)
  );

  potq_checker #(.DEPTH(DEPTH)) u_checker (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .operation(operation), .entry_key(entry_key), .rank(rank), .handle(handle),
    .out_valid(out_valid), .out_stall(out_stall),
    .status(status), .found_rank(found_rank), .found_handle(found_handle),
    .occupancy(occupancy),
    .errors(errors), .pending(pending)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  task automatic send(input logic [OP_W-1:0] op, input logic [KEY_W-1:0] key,
                      input logic [RANK_W-1:0] rnk, input logic [HANDLE_W-1:0] hnd);
    in_valid  <= 1'b1;
    operation <= op;
    entry_key <= key;
    rank      <= rnk;
    handle    <= hnd;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sent++;
  endtask

  task automatic pause_for(input int n);
    if (n > 0) begin
      in_valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  task automatic drain;
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  function automatic int gap_len();
    int x;
    x = $urandom_range(0, 99);
    if (x < 60) return 0;
    if (x < 90) return $urandom_range(1, 3);
    if (x < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [KEY_W-1:0] pick_key();
    int x;
    x = $urandom_range(0, 99);
    if (x < 70) return KEY_W'($urandom_range(0, 23));
    if (x < 80) return ($urandom_range(0, 1) != 0) ? '1 : '0;
    return KEY_W'($urandom());
  endfunction

  function automatic logic [RANK_W-1:0] pick_rank();
    int x;
    x = $urandom_range(0, 99);
    if (x < 40) return RANK_W'(100 + $urandom_range(0, 3));
    if (x < 50) return ($urandom_range(0, 1) != 0) ? '1 : '0;
    return RANK_W'($urandom());
  endfunction

  function automatic logic [OP_W-1:0] pick_op(input int ins_pct);
    int x;
    x = $urandom_range(0, 99);
    if (x < ins_pct) return OP_INSERT;
    if (x < ins_pct + (95 - ins_pct) * 55 / 100) return OP_REMOVE;
    if (x < 95) return OP_FIND;
    return OP_NONE;
  endfunction

  // receiver: random stall runs, one long hold-off once traffic is flowing
  initial begin
    int x;
    int run_left;
    bit run_val;
    bit long_done;
    run_left  = 0;
    run_val   = 1'b0;
    long_done = 1'b0;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (!long_done && sent >= 550) begin
        long_done = 1'b1;
        run_val   = 1'b1;
        run_left  = 300;
      end else if (run_left == 0) begin
        x = $urandom_range(0, 99);
        if (x < 50) begin
          run_val = 1'b0; run_left = $urandom_range(1, 8);
        end else if (x < 85) begin
          run_val = 1'b1; run_left = $urandom_range(1, 3);
        end else if (x < 93) begin
          run_val = 1'b1; run_left = $urandom_range(4, 12);
        end else if (x < 96) begin
          run_val = 1'b1; run_left = $urandom_range(20, 60);
        end else begin
          run_val = 1'b0; run_left = $urandom_range(60, 200);
        end
      end
      out_stall <= run_val;
      run_left--;
    end
  end

  initial begin
    int  b;
    int  n;
    int  ins_pct;
    bit  burst;
    rst       <= 1'b1;
    in_valid  <= 1'b0;
    operation <= '0;
    entry_key <= '0;
    rank      <= '0;
    handle    <= '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // empty table, unused code, extremes, duplicate ids on equal rank
    send(OP_FIND,   16'd5,    8'd0,   16'd0);
    send(OP_REMOVE, 16'd5,    8'd0,   16'd0);
    pause_for(gap_len());
    send(OP_NONE,   16'hFFFF, 8'hFF,  16'hFFFF);
    send(OP_INSERT, 16'h0000, 8'h00,  16'h0000);
    send(OP_INSERT, 16'hFFFF, 8'hFF,  16'hFFFF);
    pause_for(gap_len());
    send(OP_INSERT, 16'd7,    8'h80,  16'h1234);
    send(OP_INSERT, 16'd7,    8'h80,  16'h5678);
    send(OP_FIND,   16'd7,    8'h00,  16'h0000);
    send(OP_REMOVE, 16'd7,    8'h00,  16'h0000);
    send(OP_FIND,   16'd7,    8'h00,  16'h0000);
    // fill to capacity, then one insert too many
    for (n = 0; n < DEPTH - 2; n++) begin
      send(OP_INSERT, KEY_W'(100 + n), RANK_W'(n * 17), HANDLE_W'(n));
      pause_for(gap_len());
    end
    send(OP_FIND,   16'hFFFF, 8'h00,  16'h0000);

    for (b = 0; b < BLOCKS; b++) begin
      ins_pct = (b % 2 == 0) ? 20 : 70;
      if (b % 4 == 3) ins_pct = 45;
      burst = (b % 3 == 2);
      for (n = 0; n < BLOCK_ITEMS; n++) begin
        send(pick_op(ins_pct), pick_key(), pick_rank(), HANDLE_W'($urandom()));
        if (!burst) pause_for(gap_len());
      end
      if (b == 7) drain();
    end
    drain();
    repeat (DEPTH * 4) @(posedge clk);

    if (errors == 0 && pending == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
